>>> rtl/tccl_pkg.sv
`default_nettype none

package tccl_pkg;

	// Field and register widths.
	localparam int RUNE_W    = 21;
	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CUR_W     = 16;
	localparam int SHIFT_W   = 11;
	localparam int OP_W      = 2;

	// Sizing of the backspace stack, tab stops and scrolling.
	localparam int HIST_DEPTH   = 256;
	localparam int HIST_AW      = $clog2(HIST_DEPTH);
	localparam int HIST_CW      = $clog2(HIST_DEPTH + 1);
	localparam int TAB_CELLS    = 4;
	localparam int TAB_W        = $clog2(TAB_CELLS + 1);
	localparam int SCROLL_LINES = 8;

	// Derived datapath widths.
	localparam int PAD_W   = $clog2(TAB_CELLS * 255 + 1);
	localparam int SCR_W   = $clog2(SCROLL_LINES * 255 + 1);
	localparam int ARITH_W = 18;
	localparam int OFF_W   = CUR_W - 1;
	localparam int DIV_CW  = $clog2(OFF_W + 1);

	// Control characters.
	localparam logic [RUNE_W-1:0] RUNE_NUL = 21'd0;
	localparam logic [RUNE_W-1:0] RUNE_BS  = 21'd8;
	localparam logic [RUNE_W-1:0] RUNE_TAB = 21'd9;
	localparam logic [RUNE_W-1:0] RUNE_NL  = 21'd10;
	localparam logic [RUNE_W-1:0] RUNE_CR  = 21'd13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_MIN_X   = 'd0,
		REG_WIN_MIN_Y   = 'd1,
		REG_WIN_MAX_X   = 'd2,
		REG_WIN_MAX_Y   = 'd3,
		REG_LINE_HEIGHT = 'd4,
		REG_CELL_WIDTH  = 'd5
	} cfg_reg_t;

	typedef enum logic [OP_W-1:0] {
		OP_COPY  = 'd0,
		OP_FILL  = 'd1,
		OP_GLYPH = 'd2
	} draw_op_t;

	typedef enum logic [2:0] {
		CLS_IGNORE,
		CLS_NL,
		CLS_CR,
		CLS_TAB,
		CLS_BS,
		CLS_DRAW
	} rune_cls_t;

	typedef enum logic [2:0] {
		CX_HOLD,
		CX_ADD_GW,
		CX_ADD_PAD,
		CX_BACK
	} cx_sel_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_COPY,
		EM_SCROLL_FILL,
		EM_TAB_FILL,
		EM_BS_FILL,
		EM_CHAR_FILL,
		EM_GLYPH
	} emit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LINE,
		ST_COPY,
		ST_SCROLL_FILL,
		ST_TAB_START,
		ST_TAB_DIV,
		ST_TAB_FILL,
		ST_BS_FILL,
		ST_CHAR_FILL,
		ST_CHAR_GLYPH
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      take;
		logic      clr_line;
		logic      adv_line;
		logic      div_start;
		logic      pad_load;
		logic      push;
		logic      pop;
		cx_sel_t   cx_sel;
		emit_t     emit;
		logic      last;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		rune_cls_t cls;
		logic      wrap;
		logic      scroll;
		logic      hist_empty;
		logic      div_done;
		logic      slot_free;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/tccl_char_if.sv
`default_nettype none

interface tccl_char_if;
	logic                          valid;
	logic                          ready;
	logic [tccl_pkg::RUNE_W-1:0]   rune_code;
	logic [tccl_pkg::BYTE_W-1:0]   glyph_width;

	modport source (output valid, output rune_code, output glyph_width, input ready);
	modport sink (input valid, input rune_code, input glyph_width, output ready);
endinterface

`default_nettype wire

>>> rtl/tccl_cmd_if.sv
`default_nettype none

interface tccl_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [tccl_pkg::OP_W-1:0]           draw_op;
	logic signed [tccl_pkg::CUR_W-1:0]   rect_x0;
	logic signed [tccl_pkg::CUR_W-1:0]   rect_y0;
	logic signed [tccl_pkg::CUR_W-1:0]   rect_x1;
	logic signed [tccl_pkg::CUR_W-1:0]   rect_y1;
	logic [tccl_pkg::SHIFT_W-1:0]        shift_y;
	logic [tccl_pkg::RUNE_W-1:0]         glyph_code;
	logic                                last;

	modport source (
		output valid, output draw_op, output rect_x0, output rect_y0, output rect_x1,
		output rect_y1, output shift_y, output glyph_code, output last, input ready
	);
	modport sink (
		input valid, input draw_op, input rect_x0, input rect_y0, input rect_x1,
		input rect_y1, input shift_y, input glyph_code, input last, output ready
	);
endinterface

`default_nettype wire

>>> rtl/tccl_ctrl.sv
`default_nettype none

module tccl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  tccl_pkg::dp_sts_t       sts,
	output tccl_pkg::ctl_cmd_t      cmd
);

	tccl_pkg::ctl_state_t state_q;
	tccl_pkg::ctl_state_t state_d;
	tccl_pkg::ctl_state_t after_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == tccl_pkg::ST_IDLE);

	// Where to go once a line break is done: a wrapped tab or glyph carries on.
	always_comb begin
		case (sts.cls)
			tccl_pkg::CLS_TAB:  after_line = tccl_pkg::ST_TAB_START;
			tccl_pkg::CLS_DRAW: after_line = tccl_pkg::ST_CHAR_FILL;
			default:            after_line = tccl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.cx_sel    = tccl_pkg::CX_HOLD;
		cmd.emit      = tccl_pkg::EM_NONE;
		case (state_q)
			tccl_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = tccl_pkg::ST_DISPATCH;
				end
			end
			tccl_pkg::ST_DISPATCH: begin
				case (sts.cls)
					tccl_pkg::CLS_NL: begin
						state_d = tccl_pkg::ST_LINE;
					end
					tccl_pkg::CLS_CR: begin
						cmd.clr_line = 1'b1;
						state_d      = tccl_pkg::ST_IDLE;
					end
					tccl_pkg::CLS_TAB: begin
						state_d = sts.wrap ? tccl_pkg::ST_LINE : tccl_pkg::ST_TAB_START;
					end
					tccl_pkg::CLS_BS: begin
						if (sts.hist_empty) begin
							state_d = tccl_pkg::ST_IDLE;
						end else begin
							cmd.pop = 1'b1;
							state_d = tccl_pkg::ST_BS_FILL;
						end
					end
					tccl_pkg::CLS_DRAW: begin
						state_d = sts.wrap ? tccl_pkg::ST_LINE : tccl_pkg::ST_CHAR_FILL;
					end
					default: begin
						state_d = tccl_pkg::ST_IDLE;
					end
				endcase
			end
			tccl_pkg::ST_LINE: begin
				if (sts.scroll) begin
					state_d = tccl_pkg::ST_COPY;
				end else begin
					cmd.adv_line = 1'b1;
					cmd.clr_line = 1'b1;
					state_d      = after_line;
				end
			end
			tccl_pkg::ST_COPY: begin
				if (sts.slot_free) begin
					cmd.emit = tccl_pkg::EM_COPY;
					state_d  = tccl_pkg::ST_SCROLL_FILL;
				end
			end
			tccl_pkg::ST_SCROLL_FILL: begin
				if (sts.slot_free) begin
					cmd.emit     = tccl_pkg::EM_SCROLL_FILL;
					cmd.last     = (sts.cls == tccl_pkg::CLS_NL);
					cmd.adv_line = 1'b1;
					cmd.clr_line = 1'b1;
					state_d      = after_line;
				end
			end
			tccl_pkg::ST_TAB_START: begin
				cmd.div_start = 1'b1;
				state_d       = tccl_pkg::ST_TAB_DIV;
			end
			tccl_pkg::ST_TAB_DIV: begin
				if (sts.div_done) begin
					cmd.pad_load = 1'b1;
					state_d      = tccl_pkg::ST_TAB_FILL;
				end
			end
			tccl_pkg::ST_TAB_FILL: begin
				if (sts.slot_free) begin
					cmd.emit   = tccl_pkg::EM_TAB_FILL;
					cmd.last   = 1'b1;
					cmd.push   = 1'b1;
					cmd.cx_sel = tccl_pkg::CX_ADD_PAD;
					state_d    = tccl_pkg::ST_IDLE;
				end
			end
			tccl_pkg::ST_BS_FILL: begin
				if (sts.slot_free) begin
					cmd.emit   = tccl_pkg::EM_BS_FILL;
					cmd.last   = 1'b1;
					cmd.cx_sel = tccl_pkg::CX_BACK;
					state_d    = tccl_pkg::ST_IDLE;
				end
			end
			tccl_pkg::ST_CHAR_FILL: begin
				if (sts.slot_free) begin
					cmd.emit = tccl_pkg::EM_CHAR_FILL;
					cmd.push = 1'b1;
					state_d  = tccl_pkg::ST_CHAR_GLYPH;
				end
			end
			tccl_pkg::ST_CHAR_GLYPH: begin
				if (sts.slot_free) begin
					cmd.emit   = tccl_pkg::EM_GLYPH;
					cmd.last   = 1'b1;
					cmd.cx_sel = tccl_pkg::CX_ADD_GW;
					state_d    = tccl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tccl_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A command is only ever loaded into a free output register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != tccl_pkg::EM_NONE) |-> sts.slot_free)
		else $error("command issued while output register occupied");
`endif

endmodule

`default_nettype wire

>>> rtl/tccl_dp.sv
`default_nettype none

module tccl_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tccl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tccl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [tccl_pkg::RUNE_W-1:0]    rune_code,
	input  wire logic [tccl_pkg::BYTE_W-1:0]    glyph_width,
	input  tccl_pkg::ctl_cmd_t                  cmd,
	output tccl_pkg::dp_sts_t                   sts,
	tccl_cmd_if.source                          cmd_out
);

	localparam int RUNE_W    = tccl_pkg::RUNE_W;
	localparam int BYTE_W    = tccl_pkg::BYTE_W;
	localparam int CFG_W     = tccl_pkg::CFG_W;
	localparam int CUR_W     = tccl_pkg::CUR_W;
	localparam int SHIFT_W   = tccl_pkg::SHIFT_W;
	localparam int ARITH_W   = tccl_pkg::ARITH_W;
	localparam int PAD_W     = tccl_pkg::PAD_W;
	localparam int SCR_W     = tccl_pkg::SCR_W;
	localparam int OFF_W     = tccl_pkg::OFF_W;
	localparam int DIV_CW    = tccl_pkg::DIV_CW;
	localparam int TAB_W     = tccl_pkg::TAB_W;
	localparam int HIST_AW   = tccl_pkg::HIST_AW;
	localparam int HIST_CW   = tccl_pkg::HIST_CW;
	localparam int TAB_CELLS = tccl_pkg::TAB_CELLS;

	// Configuration registers.
	logic [CFG_W-1:0]  win_min_x_q, win_min_y_q, win_max_x_q, win_max_y_q;
	logic [BYTE_W-1:0] line_height_q, cell_width_q;

	// Cursor, stack and current item.
	logic [CUR_W-1:0]   cur_x_q, cur_y_q;
	logic [HIST_CW-1:0] count_q;
	logic [HIST_CW-1:0] count_dec;
	logic [CUR_W-1:0]   hist_mem [tccl_pkg::HIST_DEPTH];
	logic [CUR_W-1:0]   back_q;
	logic [RUNE_W-1:0]  rune_q;
	logic [BYTE_W-1:0]  gw_q;

	// Tab divider.
	logic [OFF_W-1:0]  off_q;
	logic [BYTE_W-1:0] rem_q;
	logic [TAB_W-1:0]  cells_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [PAD_W-1:0]  pad_q;
	logic [BYTE_W:0]   trial, trial_sub;
	logic              q_bit;
	logic [TAB_W:0]    cells_dbl, cells_sub;
	logic [TAB_W-1:0]  tab_left;
	logic [PAD_W-1:0]  pad_prod, tab_span;
	logic [SCR_W-1:0]  scroll_px;
	logic [OFF_W-1:0]  off_start;

	// Extended signed views for the geometry arithmetic.
	logic signed [ARITH_W-1:0] minx_e, miny_e, maxx_e, maxy_e;
	logic signed [ARITH_W-1:0] cx_e, cy_e, h_e, gw_e, pad_e, o_e, span_e;
	logic signed [ARITH_W-1:0] y_h, y_scr, x_gw, x_pad, maxy_o, off_e;

	// Output register.
	logic                      out_valid_q;
	tccl_pkg::draw_op_t        op_q, op_d;
	logic [CUR_W-1:0]          x0_q, y0_q, x1_q, y1_q, x0_d, y0_d, x1_d, y1_d;
	logic [SHIFT_W-1:0]        shift_q, shift_d;
	logic [RUNE_W-1:0]         glyph_q, glyph_d;
	logic                      last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_x_q   <= '0;
			win_min_y_q   <= '0;
			win_max_x_q   <= '1;
			win_max_y_q   <= '1;
			line_height_q <= BYTE_W'(16);
			cell_width_q  <= BYTE_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				tccl_pkg::REG_WIN_MIN_X:   win_min_x_q   <= cfg_data;
				tccl_pkg::REG_WIN_MIN_Y:   win_min_y_q   <= cfg_data;
				tccl_pkg::REG_WIN_MAX_X:   win_max_x_q   <= cfg_data;
				tccl_pkg::REG_WIN_MAX_Y:   win_max_y_q   <= cfg_data;
				tccl_pkg::REG_LINE_HEIGHT: line_height_q <= cfg_data[BYTE_W-1:0];
				tccl_pkg::REG_CELL_WIDTH:  cell_width_q  <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign minx_e = {{(ARITH_W-CFG_W){1'b0}}, win_min_x_q};
	assign miny_e = {{(ARITH_W-CFG_W){1'b0}}, win_min_y_q};
	assign maxx_e = {{(ARITH_W-CFG_W){1'b0}}, win_max_x_q};
	assign maxy_e = {{(ARITH_W-CFG_W){1'b0}}, win_max_y_q};
	assign cx_e   = {{(ARITH_W-CUR_W){cur_x_q[CUR_W-1]}}, cur_x_q};
	assign cy_e   = {{(ARITH_W-CUR_W){cur_y_q[CUR_W-1]}}, cur_y_q};
	assign h_e    = {{(ARITH_W-BYTE_W){1'b0}}, line_height_q};
	assign gw_e   = {{(ARITH_W-BYTE_W){1'b0}}, gw_q};
	assign pad_e  = {{(ARITH_W-PAD_W){1'b0}}, pad_q};
	assign o_e    = {{(ARITH_W-SCR_W){1'b0}}, scroll_px};
	assign span_e = {{(ARITH_W-PAD_W){1'b0}}, tab_span};

	assign scroll_px = SCR_W'(tccl_pkg::SCROLL_LINES) * SCR_W'(line_height_q);
	assign tab_span  = PAD_W'(TAB_CELLS) * PAD_W'(cell_width_q);

	assign y_h    = cy_e + h_e;
	assign y_scr  = cy_e - o_e + h_e;
	assign x_gw   = cx_e + gw_e;
	assign x_pad  = cx_e + pad_e;
	assign maxy_o = maxy_e - o_e;
	assign off_e  = cx_e - minx_e;

	// A cursor left of the margin counts as no offset at all.
	assign off_start = off_e[ARITH_W-1] ? '0 : off_e[OFF_W-1:0];

	always_comb begin
		case (rune_q)
			tccl_pkg::RUNE_NUL: sts.cls = tccl_pkg::CLS_IGNORE;
			tccl_pkg::RUNE_NL:  sts.cls = tccl_pkg::CLS_NL;
			tccl_pkg::RUNE_CR:  sts.cls = tccl_pkg::CLS_CR;
			tccl_pkg::RUNE_TAB: sts.cls = tccl_pkg::CLS_TAB;
			tccl_pkg::RUNE_BS:  sts.cls = tccl_pkg::CLS_BS;
			default:            sts.cls = tccl_pkg::CLS_DRAW;
		endcase
		case (sts.cls)
			tccl_pkg::CLS_TAB:  sts.wrap = (cx_e >= maxx_e - span_e);
			tccl_pkg::CLS_DRAW: sts.wrap = (cx_e >= maxx_e - gw_e);
			default:            sts.wrap = 1'b0;
		endcase
		sts.scroll     = (y_h >= maxy_e);
		sts.hist_empty = (count_q == '0);
		sts.div_done   = (div_cnt_q == '0);
		sts.slot_free  = !out_valid_q || cmd_out.ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rune_q <= rune_code;
			gw_q   <= glyph_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (cfg_we && cfg_index == tccl_pkg::REG_WIN_MIN_X) begin
			cur_x_q <= CUR_W'(cfg_data);
		end else if (cfg_we && cfg_index == tccl_pkg::REG_WIN_MIN_Y) begin
			cur_y_q <= CUR_W'(cfg_data);
		end else begin
			if (cmd.adv_line) begin
				cur_y_q <= sts.scroll ? y_scr[CUR_W-1:0] : y_h[CUR_W-1:0];
			end
			if (cmd.clr_line) begin
				cur_x_q <= CUR_W'(win_min_x_q);
			end else begin
				case (cmd.cx_sel)
					tccl_pkg::CX_ADD_GW:  cur_x_q <= x_gw[CUR_W-1:0];
					tccl_pkg::CX_ADD_PAD: cur_x_q <= x_pad[CUR_W-1:0];
					tccl_pkg::CX_BACK:    cur_x_q <= back_q;
					default: ;
				endcase
			end
		end
	end

	// Backspace stack: the count is control state, the entries are plain storage.
	assign count_dec = count_q - HIST_CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.take && count_q >= HIST_CW'(tccl_pkg::HIST_DEPTH)) begin
			count_q <= '0;
		end else if (cmd.clr_line) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + HIST_CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hist_mem[count_q[HIST_AW-1:0]] <= cur_x_q;
		end
		if (cmd.pop) begin
			back_q <= hist_mem[count_dec[HIST_AW-1:0]];
		end
	end

	// Restoring divider, one quotient bit a cycle; only the quotient modulo the
	// tab stop spacing is kept, folded in as the bits arrive.
	assign trial     = {rem_q, off_q[OFF_W-1]};
	assign trial_sub = trial - {1'b0, cell_width_q};
	assign q_bit     = (trial >= {1'b0, cell_width_q});
	assign cells_dbl = {cells_q, q_bit};
	assign cells_sub = cells_dbl - (TAB_W+1)'(TAB_CELLS);
	assign tab_left  = TAB_W'(TAB_CELLS) - cells_q;
	assign pad_prod  = PAD_W'(tab_left) * PAD_W'(cell_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DIV_CW'(OFF_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DIV_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			off_q   <= off_start;
			rem_q   <= '0;
			cells_q <= '0;
		end else if (div_cnt_q != '0) begin
			off_q   <= {off_q[OFF_W-2:0], 1'b0};
			rem_q   <= q_bit ? trial_sub[BYTE_W-1:0] : trial[BYTE_W-1:0];
			cells_q <= (cells_dbl >= (TAB_W+1)'(TAB_CELLS)) ? cells_sub[TAB_W-1:0]
			                                                : cells_dbl[TAB_W-1:0];
		end
		if (cmd.pad_load) begin
			pad_q <= pad_prod;
		end
	end

	// Command payload for each kind of beat.
	always_comb begin
		op_d    = tccl_pkg::OP_FILL;
		x0_d    = cur_x_q;
		y0_d    = cur_y_q;
		x1_d    = x_gw[CUR_W-1:0];
		y1_d    = y_h[CUR_W-1:0];
		shift_d = '0;
		glyph_d = '0;
		case (cmd.emit)
			tccl_pkg::EM_COPY: begin
				op_d    = tccl_pkg::OP_COPY;
				x0_d    = CUR_W'(win_min_x_q);
				y0_d    = CUR_W'(win_min_y_q);
				x1_d    = CUR_W'(win_max_x_q);
				y1_d    = maxy_o[CUR_W-1:0];
				shift_d = SHIFT_W'(scroll_px);
			end
			tccl_pkg::EM_SCROLL_FILL: begin
				x0_d = CUR_W'(win_min_x_q);
				y0_d = maxy_o[CUR_W-1:0];
				x1_d = CUR_W'(win_max_x_q);
				y1_d = CUR_W'(win_max_y_q);
			end
			tccl_pkg::EM_TAB_FILL: begin
				x1_d = x_pad[CUR_W-1:0];
			end
			tccl_pkg::EM_BS_FILL: begin
				x0_d = back_q;
				x1_d = cur_x_q;
			end
			tccl_pkg::EM_CHAR_FILL: ;
			tccl_pkg::EM_GLYPH: begin
				op_d    = tccl_pkg::OP_GLYPH;
				glyph_d = rune_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != tccl_pkg::EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (cmd_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != tccl_pkg::EM_NONE) begin
			op_q    <= op_d;
			x0_q    <= x0_d;
			y0_q    <= y0_d;
			x1_q    <= x1_d;
			y1_q    <= y1_d;
			shift_q <= shift_d;
			glyph_q <= glyph_d;
			last_q  <= cmd.last;
		end
	end

	assign cmd_out.valid      = out_valid_q;
	assign cmd_out.draw_op    = op_q;
	assign cmd_out.rect_x0    = x0_q;
	assign cmd_out.rect_y0    = y0_q;
	assign cmd_out.rect_x1    = x1_q;
	assign cmd_out.rect_y1    = y1_q;
	assign cmd_out.shift_y    = shift_q;
	assign cmd_out.glyph_code = glyph_q;
	assign cmd_out.last       = last_q;

`ifndef SYNTHESIS
	// Backspace never pops an empty stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("stack popped while empty");

	// A push always finds room, since a full stack is emptied when the item is taken.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q < HIST_CW'(tccl_pkg::HIST_DEPTH)))
		else $error("stack pushed while full");

	// Starting the divider keeps it busy on the following cycle.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider reported done straight after start");
`endif

endmodule

`default_nettype wire

>>> rtl/text_console_cursor_layout.sv
// Cursor layout engine for a pixel text console.
//
// char_in takes one beat per decoded character (rune_code, glyph_width).
// cmd_out gives zero to four drawing commands per character: copy-up and
// fill for a scroll, fills for blanking, and glyph draws. The final
// beat caused by a character carries last. Code 0, return, a newline
// that does not scroll and backspace with an empty stack give no beat at all.
// The configuration port writes the window edges, line height and cell
// width; writing either origin register also moves the cursor there.
// Writes are to be made only while the block is idle.
//
// One character is worked on at a time. A printable character gives a fill
// beat and a glyph beat; a tab first runs the bit-serial divider that finds
// the tab column (fifteen steps), then gives one fill beat. A wrap or a
// scroll first passes through the line break states.
// Commands leave through a single output register, so a stalled receiver
// holds the controller in its current emit state; the next character is
// accepted as soon as the last beat is loaded. Reset homes the cursor to
// the reset origin, empties the backspace stack and clears the output.
`default_nettype none

module text_console_cursor_layout (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tccl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tccl_pkg::CFG_W-1:0]     cfg_data,
	tccl_char_if.sink                           char_in,
	tccl_cmd_if.source                          cmd_out
);

	// Command and status buses between the sequencer and the datapath.
	tccl_pkg::ctl_cmd_t cmd;
	tccl_pkg::dp_sts_t  sts;

	// The sequencer decides which commands to issue and when; it only moves on
	// from an emit state once the output register can take the beat.
	tccl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (char_in.valid),
		.in_ready (char_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the window registers, the cursor, the backspace
	// stack memory, the tab divider and the output register.
	tccl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rune_code   (char_in.rune_code),
		.glyph_width (char_in.glyph_width),
		.cmd         (cmd),
		.sts         (sts),
		.cmd_out     (cmd_out)
	);

endmodule

`default_nettype wire

>>> dv/tb_text_console_cursor_layout.sv
`default_nettype none

// Testbench for the text console cursor layout engine.
//
// Characters go in on char_in, drawing commands come out on cmd_out. A model
// of the cursor, the window registers and the backspace stack lives in this
// module. Each character accepted on char_in is laid out at once by that
// model, and the commands it should cause are queued. Every command beat that
// leaves the block is compared field by field with the oldest queued command.
module tb_text_console_cursor_layout;
	timeunit 1ns;
	timeprecision 1ps;

	// Upper bound on the whole run.
	localparam int LIMIT_CYCLES = 300000;
	// Cycles to allow after the last expected beat. This covers a tab with
	// a wrap and a scroll, and characters that cause no beat at all.
	localparam int SETTLE_CYCLES = 48;
	// Characters sent in each phase of random traffic.
	localparam int RANDOM_PER_PHASE = 22;

	// Register indexes that the block has no register for.
	localparam logic [tccl_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [tccl_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct packed {
		tccl_pkg::draw_op_t                op;
		logic [tccl_pkg::CUR_W-1:0]        x0;
		logic [tccl_pkg::CUR_W-1:0]        y0;
		logic [tccl_pkg::CUR_W-1:0]        x1;
		logic [tccl_pkg::CUR_W-1:0]        y1;
		logic [tccl_pkg::SHIFT_W-1:0]      shift;
		logic [tccl_pkg::RUNE_W-1:0]       glyph;
		logic                              last;
	} draw_cmd_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [tccl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tccl_pkg::CFG_W-1:0]     cfg_data;

	tccl_char_if char_if ();
	tccl_cmd_if  cmd_if ();

	text_console_cursor_layout dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_in   (char_if),
		.cmd_out   (cmd_if)
	);

	// Our copy of the registers and the layout state. The cursor is held
	// as a sign-extended 16-bit value, just as the block keeps it.
	int min_x, min_y, max_x, max_y, line_h, cell_w;
	int cur_x, cur_y;
	int back_stack [tccl_pkg::HIST_DEPTH];
	int stack_fill;

	// Commands still owed by the block, oldest first.
	draw_cmd_t pending_cmds [$];

	int fail_count;
	// While set, neither side inserts idle cycles.
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cuts a value down to 16 bits and sign-extends it again.
	function automatic int wrap16(int v);
		logic signed [tccl_pkg::CUR_W-1:0] t;
		t = v[tccl_pkg::CUR_W-1:0];
		return int'(t);
	endfunction

	function automatic int idle_gap();
		return quiet ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic void queue_cmd(tccl_pkg::draw_op_t op, int x0, int y0, int x1,
			int y1, int shift, logic [tccl_pkg::RUNE_W-1:0] glyph);
		draw_cmd_t c;
		c.op    = op;
		c.x0    = x0[tccl_pkg::CUR_W-1:0];
		c.y0    = y0[tccl_pkg::CUR_W-1:0];
		c.x1    = x1[tccl_pkg::CUR_W-1:0];
		c.y1    = y1[tccl_pkg::CUR_W-1:0];
		c.shift = shift[tccl_pkg::SHIFT_W-1:0];
		c.glyph = glyph;
		c.last  = 1'b0;
		pending_cmds.push_back(c);
	endfunction

	// Moves down one text line and back to the left margin. When the cursor
	// sits on the bottom line the window is first scrolled up by a block of
	// lines: a copy of everything below moves up, and the freed strip at the
	// bottom is blanked.
	function automatic void line_feed();
		int h;
		int sh;
		h = line_h;
		if (cur_y + h >= max_y) begin
			sh = tccl_pkg::SCROLL_LINES * h;
			queue_cmd(tccl_pkg::OP_COPY, min_x, min_y, max_x, max_y - sh, sh, '0);
			queue_cmd(tccl_pkg::OP_FILL, min_x, max_y - sh, max_x, max_y, 0, '0);
			cur_y = wrap16(cur_y - sh);
		end
		cur_y = wrap16(cur_y + h);
		cur_x = min_x;
		stack_fill = 0;
	endfunction

	// Lays out one accepted character: updates the cursor and the stack and
	// queues the commands it causes, flagging the final one.
	function automatic void layout_char(logic [tccl_pkg::RUNE_W-1:0] rune,
			logic [tccl_pkg::BYTE_W-1:0] gw_bits);
		int h;
		int gw;
		int w;
		int off;
		int cells;
		int pad;
		int back;
		int base;
		draw_cmd_t tail;
		h = line_h;
		gw = int'(gw_bits);
		base = pending_cmds.size();
		// A full stack is thrown away before the character is looked at.
		if (stack_fill >= tccl_pkg::HIST_DEPTH)
			stack_fill = 0;
		case (rune)
			tccl_pkg::RUNE_NUL: ;
			tccl_pkg::RUNE_NL: line_feed();
			tccl_pkg::RUNE_CR: begin
				cur_x = min_x;
				stack_fill = 0;
			end
			tccl_pkg::RUNE_TAB: begin
				w = cell_w;
				if (cur_x >= max_x - tccl_pkg::TAB_CELLS * w)
					line_feed();
				// A cursor left of the margin counts as being on it.
				off = cur_x - min_x;
				if (off < 0)
					off = 0;
				cells = (w > 0) ? (off / w) % tccl_pkg::TAB_CELLS : 0;
				pad = (tccl_pkg::TAB_CELLS - cells) * w;
				back_stack[stack_fill] = cur_x;
				stack_fill++;
				queue_cmd(tccl_pkg::OP_FILL, cur_x, cur_y, cur_x + pad, cur_y + h, 0, '0);
				cur_x = wrap16(cur_x + pad);
			end
			tccl_pkg::RUNE_BS: begin
				if (stack_fill > 0) begin
					stack_fill--;
					back = back_stack[stack_fill];
					queue_cmd(tccl_pkg::OP_FILL, back, cur_y, cur_x, cur_y + h, 0, '0);
					cur_x = back;
				end
			end
			default: begin
				if (cur_x >= max_x - gw)
					line_feed();
				back_stack[stack_fill] = cur_x;
				stack_fill++;
				queue_cmd(tccl_pkg::OP_FILL, cur_x, cur_y, cur_x + gw, cur_y + h, 0, '0);
				queue_cmd(tccl_pkg::OP_GLYPH, cur_x, cur_y, cur_x + gw, cur_y + h, 0, rune);
				cur_x = wrap16(cur_x + gw);
			end
		endcase
		if (pending_cmds.size() > base) begin
			tail = pending_cmds.pop_back();
			tail.last = 1'b1;
			pending_cmds.push_back(tail);
		end
	endfunction

	function automatic string describe_cmd(draw_cmd_t c);
		return $sformatf("op=%0d rect=(%0d,%0d)-(%0d,%0d) shift=%0d glyph=%0h last=%0b",
			c.op, $signed(c.x0), $signed(c.y0), $signed(c.x1), $signed(c.y1),
			c.shift, c.glyph, c.last);
	endfunction

	function automatic void note_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", what);
	endfunction

	// Writes one register at a clock edge and mirrors the write. The write
	// enable is dropped again before the task returns.
	task automatic write_reg(input logic [tccl_pkg::CFG_IDX_W-1:0] idx,
			input logic [tccl_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			tccl_pkg::REG_WIN_MIN_X: begin
				min_x = int'(val);
				cur_x = min_x;
			end
			tccl_pkg::REG_WIN_MIN_Y: begin
				min_y = int'(val);
				cur_y = min_y;
			end
			tccl_pkg::REG_WIN_MAX_X:   max_x = int'(val);
			tccl_pkg::REG_WIN_MAX_Y:   max_y = int'(val);
			tccl_pkg::REG_LINE_HEIGHT: line_h = int'(val[tccl_pkg::BYTE_W-1:0]);
			tccl_pkg::REG_CELL_WIDTH:  cell_w = int'(val[tccl_pkg::BYTE_W-1:0]);
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Writes every register. The origin writes move the cursor as well.
	task automatic apply_window(input int mnx, input int mny, input int mxx, input int mxy,
			input int lh, input int cw);
		write_reg(tccl_pkg::REG_WIN_MIN_X, mnx[tccl_pkg::CFG_W-1:0]);
		write_reg(tccl_pkg::REG_WIN_MIN_Y, mny[tccl_pkg::CFG_W-1:0]);
		write_reg(tccl_pkg::REG_WIN_MAX_X, mxx[tccl_pkg::CFG_W-1:0]);
		write_reg(tccl_pkg::REG_WIN_MAX_Y, mxy[tccl_pkg::CFG_W-1:0]);
		write_reg(tccl_pkg::REG_LINE_HEIGHT, lh[tccl_pkg::CFG_W-1:0]);
		write_reg(tccl_pkg::REG_CELL_WIDTH, cw[tccl_pkg::CFG_W-1:0]);
	endtask

	// Offers one character after a random gap and lays it out once the
	// beat has been taken. With no gap, valid simply stays high from the
	// previous beat so that characters go back to back.
	task automatic put_char(input logic [tccl_pkg::RUNE_W-1:0] rune,
			input logic [tccl_pkg::BYTE_W-1:0] gw);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			char_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.rune_code <= rune;
		char_if.glyph_width <= gw;
		do @(posedge clk); while (!char_if.ready);
		layout_char(rune, gw);
	endtask

	// Holds off the input until every owed command has come out, then
	// gives the block time to finish characters that cause no beat.
	task automatic settle();
		char_if.valid <= 1'b0;
		do @(posedge clk); while (pending_cmds.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_printables();
		apply_window(0, 0, 4095, 4095, 16, 8);
		// Lowest drawable code with no width, then the widest glyph with
		// every code bit set, then alternating bit patterns.
		put_char(21'd1, 8'd0);
		put_char(21'h1FFFFF, 8'd255);
		put_char(21'h155555, 8'h55);
		put_char(21'h0AAAAA, 8'hAA);
		settle();
	endtask

	task automatic test_controls();
		put_char(21'd65, 8'd9);
		put_char(tccl_pkg::RUNE_TAB, 8'd0);
		put_char(tccl_pkg::RUNE_BS, 8'd0);
		put_char(tccl_pkg::RUNE_NL, 8'd0);
		// The newline emptied the stack, so this backspace does nothing.
		put_char(tccl_pkg::RUNE_BS, 8'd0);
		put_char(tccl_pkg::RUNE_NUL, 8'd77);
		put_char(21'd66, 8'd12);
		put_char(tccl_pkg::RUNE_CR, 8'd0);
		settle();
	endtask

	task automatic test_wrap_and_scroll();
		// A small window: three glyphs of 20 pixels do not fit on a line,
		// and the second line is already the bottom one.
		apply_window(10, 20, 60, 70, 25, 8);
		put_char(21'd67, 8'd20);
		put_char(21'd68, 8'd20);
		put_char(21'd69, 8'd20);
		put_char(tccl_pkg::RUNE_NL, 8'd0);
		put_char(21'd70, 8'd40);
		put_char(21'd71, 8'd40);
		settle();
	endtask

	task automatic test_tab_corners();
		// Zero cell width: the tab blanks nothing and stays put.
		apply_window(0, 0, 400, 100, 10, 0);
		put_char(tccl_pkg::RUNE_TAB, 8'd0);
		settle();
		// Four of the widest cells do not fit, so the tab wraps first.
		write_reg(tccl_pkg::REG_CELL_WIDTH, 12'd255);
		put_char(tccl_pkg::RUNE_TAB, 8'd0);
		settle();
		// An odd cell width with the cursor off the tab grid.
		write_reg(tccl_pkg::REG_CELL_WIDTH, 12'd7);
		put_char(21'd97, 8'd3);
		put_char(tccl_pkg::RUNE_TAB, 8'd0);
		put_char(tccl_pkg::RUNE_TAB, 8'd0);
		settle();
	endtask

	task automatic test_margin_moves();
		apply_window(0, 0, 4095, 4095, 16, 8);
		put_char(21'd72, 8'd50);
		put_char(21'd73, 8'd50);
		settle();
		// Moving the margin right of the stacked positions lets a backspace
		// put the cursor left of the margin; the tab then counts from it.
		write_reg(tccl_pkg::REG_WIN_MIN_X, 12'd300);
		put_char(tccl_pkg::RUNE_BS, 8'd0);
		put_char(tccl_pkg::RUNE_TAB, 8'd0);
		settle();
		// Back at the left edge, the popped position lies right of the
		// cursor and the blanking rectangle comes out reversed.
		write_reg(tccl_pkg::REG_WIN_MIN_X, 12'd0);
		put_char(tccl_pkg::RUNE_BS, 8'd0);
		settle();
	endtask

	task automatic test_odd_window();
		// Origin at the far corner and the limits at zero: every glyph wraps
		// and every line feed scrolls by the tallest possible block.
		apply_window(4095, 4095, 0, 0, 255, 255);
		put_char(21'd64, 8'd0);
		put_char(tccl_pkg::RUNE_NL, 8'd0);
		put_char(tccl_pkg::RUNE_TAB, 8'd0);
		settle();
		// Writes to indexes with no register behind them change nothing.
		write_reg(REG_UNUSED_LO, 12'hFFF);
		write_reg(REG_UNUSED_HI, 12'h000);
		// Only the low byte reaches the line height, which becomes zero.
		write_reg(tccl_pkg::REG_LINE_HEIGHT, 12'hF00);
		put_char(tccl_pkg::RUNE_NL, 8'd0);
		put_char(21'd64, 8'd3);
		settle();
	endtask

	// A random window that is small enough for frequent wraps and scrolls,
	// or with the edges anywhere at all.
	task automatic random_window(input bit anywhere);
		int x0;
		int y0;
		if (anywhere) begin
			apply_window($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 255), $urandom_range(0, 255));
		end else begin
			x0 = $urandom_range(0, 300);
			y0 = $urandom_range(0, 300);
			apply_window(x0, y0, x0 + $urandom_range(60, 700), y0 + $urandom_range(40, 400),
				$urandom_range(1, 40), $urandom_range(1, 24));
		end
	endtask

	// Mostly drawable characters, with a fair share of line feeds, tabs and
	// backspaces, a few returns and ignored codes, and some low codes that
	// may land on a control character by chance.
	task automatic send_random_char();
		int pick;
		logic [tccl_pkg::RUNE_W-1:0] rune;
		logic [tccl_pkg::BYTE_W-1:0] gw;
		pick = $urandom_range(0, 99);
		gw = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
		                                 : 8'($urandom_range(0, 24));
		if (pick < 50)
			rune = 21'($urandom_range(32, 21'h1FFFFF));
		else if (pick < 65)
			rune = tccl_pkg::RUNE_NL;
		else if (pick < 75)
			rune = tccl_pkg::RUNE_TAB;
		else if (pick < 90)
			rune = tccl_pkg::RUNE_BS;
		else if (pick < 95)
			rune = tccl_pkg::RUNE_CR;
		else if (pick < 97)
			rune = tccl_pkg::RUNE_NUL;
		else
			rune = 21'($urandom_range(1, 31));
		put_char(rune, gw);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: random_window(1'b0);
				1: apply_window(0, 0, 4095, 4095, 255, 255);
				2: random_window(1'b0);
				default: random_window(1'b1);
			endcase
			// One phase runs flat out on both sides.
			quiet = (phase == 2);
			repeat (RANDOM_PER_PHASE) send_random_char();
			settle();
		end
		quiet = 1'b0;
	endtask

	// Receiver: draws a stall before each beat and then takes it.
	initial begin
		int stall;
		cmd_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = idle_gap();
			if (stall > 0) begin
				cmd_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cmd_if.ready <= 1'b1;
			do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
		end
	end

	// Every beat taken on cmd_out is matched against the oldest owed command.
	always @(posedge clk) begin
		draw_cmd_t seen;
		draw_cmd_t want;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			seen.op    = tccl_pkg::draw_op_t'(cmd_if.draw_op);
			seen.x0    = cmd_if.rect_x0;
			seen.y0    = cmd_if.rect_y0;
			seen.x1    = cmd_if.rect_x1;
			seen.y1    = cmd_if.rect_y1;
			seen.shift = cmd_if.shift_y;
			seen.glyph = cmd_if.glyph_code;
			seen.last  = cmd_if.last;
			if (pending_cmds.size() == 0) begin
				note_failure({"unexpected command: ", describe_cmd(seen)});
			end else begin
				want = pending_cmds.pop_front();
				if (seen.op !== want.op || seen.x0 !== want.x0 || seen.y0 !== want.y0 ||
						seen.x1 !== want.x1 || seen.y1 !== want.y1 ||
						seen.shift !== want.shift || seen.glyph !== want.glyph ||
						seen.last !== want.last)
					note_failure({"command mismatch: expected ", describe_cmd(want),
						" got ", describe_cmd(seen)});
			end
		end
	end

	// Watchdog for a block that hangs or stops answering.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		char_if.valid <= 1'b0;
		char_if.rune_code <= '0;
		char_if.glyph_width <= '0;
		fail_count = 0;
		quiet = 1'b0;
		// Register and cursor values straight after reset.
		min_x = 0;
		min_y = 0;
		max_x = 4095;
		max_y = 4095;
		line_h = 16;
		cell_w = 8;
		cur_x = 0;
		cur_y = 0;
		stack_fill = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_printables();
		test_controls();
		test_wrap_and_scroll();
		test_tab_corners();
		test_margin_moves();
		test_odd_window();
		test_random_traffic();

		settle();
		if (fail_count == 0 && pending_cmds.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
